// ----- rtl/core/crc16cr_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-16 challenge-response check: shared types and functions
// Byte-update functions for the XMODEM and reflected CCITT CRC-16 forms,
// the fixed challenge masks, and the payload records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16cr_pkg;

    // Polynomial and top-bit mask of the MSB-first XMODEM CRC.
    localparam logic [15:0] XMODEM_POLY = 16'h1021;
    localparam logic [15:0] XMODEM_TOP  = 16'h8000;

    // Masks applied to challenge bytes b0 and b3.
    localparam logic [7:0]  B0_MASK     = 8'h55;
    localparam logic [7:0]  B3_MASK     = 8'h66;

    // Record carried through the CRC stages.
    typedef struct packed {
        logic [31:0] challenge;
        logic [31:0] reply;
        logic [15:0] crc;
    } t_stage;

    // Record carried into the compare stage.
    typedef struct packed {
        logic [31:0] expected;
        logic [31:0] reply;
    } t_resp;

    // MSB-first CRC-16 byte update, polynomial 0x1021 (eight narrow steps).
    function automatic logic [15:0] xmodem_byte(input logic [15:0] crc,
                                                input logic [7:0]  d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & XMODEM_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ XMODEM_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Reflected CCITT byte update in its table-free form.
    function automatic logic [15:0] ccitt_byte(input logic [15:0] crc,
                                               input logic [7:0]  d);
        logic [7:0] t;
        t = d ^ crc[7:0];
        t = t ^ {t[3:0], 4'h0};
        return {t, crc[15:8]} ^ {12'h000, t[7:4]} ^ {5'b00000, t, 3'b000};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crc16cr_xm_stage.sv -----
// ----------------------------------------------------------------------------
// CRC-16 challenge-response check: XMODEM byte stage
// Applies one MSB-first XMODEM byte update to the running CRC and registers
// the result together with the request's challenge and reply.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cr_xm_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire crc16cr_pkg::t_stage i_data,
    input  wire logic [7:0]          i_byte,
    output logic                     o_valid,
    output crc16cr_pkg::t_stage      o_data,
    input  wire logic                i_ready
);
    import crc16cr_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic   w_load;

    // The stage takes a new request when empty or when its content moves on.
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Next payload: one byte folded into the CRC.
    always_comb begin
        n_data           = i_data;
        n_data.crc       = xmodem_byte(i_data.crc, i_byte);
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/crc16cr_cc_stage.sv -----
// ----------------------------------------------------------------------------
// CRC-16 challenge-response check: CCITT stage
// Applies the reflected CCITT byte update with challenge byte b3 to the
// XMODEM value and packs the expected response word.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cr_cc_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire crc16cr_pkg::t_stage i_data,
    output logic                     o_valid,
    output crc16cr_pkg::t_resp       o_data,
    input  wire logic                i_ready
);
    import crc16cr_pkg::*;

    logic        r_valid;
    t_resp       r_data;
    t_resp       n_data;
    logic [15:0] w_cc;
    logic        w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // CCITT update and response packing: xm_lo, cc_lo, xm_hi, cc_hi.
    always_comb begin
        w_cc            = ccitt_byte(i_data.crc, i_data.challenge[31:24] ^ B3_MASK);
        n_data.expected = {w_cc[15:8], i_data.crc[15:8], w_cc[7:0], i_data.crc[7:0]};
        n_data.reply    = i_data.reply;
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/crc16cr_cmp_stage.sv -----
// ----------------------------------------------------------------------------
// CRC-16 challenge-response check: compare and output stage
// Compares the expected response with the partner's reply and holds the
// result in the output register of the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cr_cmp_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire crc16cr_pkg::t_resp i_data,
    output logic                    o_tvalid,
    output logic [31:0]             o_tdata,
    output logic                    o_tuser,
    input  wire logic               i_tready
);
    import crc16cr_pkg::*;

    logic        r_valid;
    logic [31:0] r_resp;
    logic        r_match;
    logic        w_load;

    assign o_ready = !r_valid || i_tready;
    assign w_load  = i_valid && o_ready;

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result register: response word and the one-bit flag of the 32-bit comparison.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_resp  <= i_data.expected;
            r_match <= (i_data.expected == i_data.reply);
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_resp;
    assign o_tuser  = r_match;

endmodule

`default_nettype wire

// ----- rtl/core/crc16_challenge_response_check.sv -----
// Throughput: one request per cycle unless stalled; four register stages (two
// XMODEM byte updates, the CCITT update, the compare) each hold one request.
// Backpressure stalls the pipeline in place; an empty stage still accepts.
// Reset (synchronous, active low) clears all valid bits; payloads are not reset.
// ----------------------------------------------------------------------------
// CRC-16 challenge-response check
// Computes the expected response to a 32-bit challenge from an XMODEM and a
// reflected CCITT CRC-16 and flags whether the partner's reply matches it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_challenge_response_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] challenge, [63:32] device_reply
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] expected_response
    output logic             m_axis_tuser   // [0] reply_matches
);
    import crc16cr_pkg::*;

    t_stage w_s0_data;
    t_stage w_s1_data;
    t_stage w_s2_data;
    t_resp  w_s3_data;
    logic   w_s1_valid;
    logic   w_s2_valid;
    logic   w_s3_valid;
    logic   w_s1_ready;
    logic   w_s2_ready;
    logic   w_s3_ready;
    logic   w_s4_ready;

    // Unpack the incoming request; the CRC starts at zero.
    assign w_s0_data = '{challenge: s_axis_tdata[31:0],
                         reply:     s_axis_tdata[63:32],
                         crc:       16'h0000};

    // XMODEM update over b0 ^ 0x55.
    crc16cr_xm_stage u_xm0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (w_s1_ready),
        .i_data  (w_s0_data),
        .i_byte  (s_axis_tdata[7:0] ^ B0_MASK),
        .o_valid (w_s1_valid),
        .o_data  (w_s1_data),
        .i_ready (w_s2_ready)
    );

    // XMODEM update over ~b1.
    crc16cr_xm_stage u_xm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s1_data),
        .i_byte  (~w_s1_data.challenge[15:8]),
        .o_valid (w_s2_valid),
        .o_data  (w_s2_data),
        .i_ready (w_s3_ready)
    );

    // CCITT update over b3 ^ 0x66 and response packing.
    crc16cr_cc_stage u_cc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s3_ready),
        .i_data  (w_s2_data),
        .o_valid (w_s3_valid),
        .o_data  (w_s3_data),
        .i_ready (w_s4_ready)
    );

    // Compare and output register.
    crc16cr_cmp_stage u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s3_valid),
        .o_ready  (w_s4_ready),
        .i_data   (w_s3_data),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .i_tready (m_axis_tready)
    );

    assign s_axis_tready = w_s1_ready;

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !w_s1_valid && !w_s2_valid && !w_s3_valid)
        else $error("pipeline not empty after reset");

    // Input backpressure only when every stage is full and the output stalls.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_s1_valid && w_s2_valid && w_s3_valid
                           && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

    // An accepted request occupies the first stage in the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_s1_valid)
        else $error("accepted request lost at the first stage");

endmodule

`default_nettype wire
